// ----- src/olid_pkg.sv -----
// ----------------------------------------------------------------------------
// olid_pkg
// Shared codes, field widths and cell control type for the ordered list.
// ----------------------------------------------------------------------------
package olid_pkg;

   // field widths of the request, response and csr beats
   localparam int CMD_W    = 2;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   // capacity after reset
   localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_OUT_RANGE = 2'd2
   } status_type;

   // broadcast to every cell: which shift happens this cycle
   typedef struct packed {
      logic ins;
      logic del;
   } cell_op_type;

endpackage

// ----- src/olid_if.sv -----
// ----------------------------------------------------------------------------
// olid_if
// Valid/ready channels of the ordered list: request, response and csr write.
// ----------------------------------------------------------------------------
interface olid_req_if import olid_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [POS_W-1:0]   position;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

interface olid_rsp_if import olid_pkg::*;;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    list_length;

   modport source (output valid, output read_value, output status, output list_length,
                   input ready);
   modport sink   (input valid, input read_value, input status, input list_length,
                   output ready);
endinterface

interface olid_csr_if import olid_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/olid_cell.sv -----
// ----------------------------------------------------------------------------
// olid_cell
// One list entry: holds its word, takes its left or right neighbor on a
// shift, or loads the new value when it sits at the insert position.
// ----------------------------------------------------------------------------
module olid_cell import olid_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int POSW       = 7,
   parameter int IDX        = 0
) (
   input  logic                  clock,
   input  cell_op_type           op,
   input  logic [POSW-1:0]       pos,
   input  logic [DATA_WIDTH-1:0] ins_value,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data
);

   localparam logic [POSW-1:0] MY_IDX = POSW'(IDX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // pick the source of this entry for the next cycle
   always_comb begin
      priority if (op.ins && (MY_IDX > pos)) begin
         data_in = left_data;
      end else if (op.ins && (MY_IDX == pos)) begin
         data_in = ins_value;
      end else if (op.del && (MY_IDX >= pos)) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   // entry storage, undefined until written
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- src/ordered_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Fixed-capacity ordered list of words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one command per beat: insert, delete, get or clear, with
//   a position and, for insert, a data word. rsp_bus returns exactly one beat
//   per command with the word read (get, delete), a status and the length.
//   csr_bus writes the capacity limit; it is always ready and should only be
//   written while no command is outstanding.
// Timing:
//   one command per cycle unless a response stalls; the response appears in the
//   cycle after the request beat. Every cell decides its next word from its neighbors
//   in the same cycle, so an insert or delete moves the whole tail in one step.
// Reset:
//   synchronous; the list becomes empty, the capacity returns to 64 and no
//   response is pending. Entry contents are not cleared.
// Stall:
//   the response register holds while rsp_bus is not ready; req_bus stays
//   ready as long as the pending response is taken in the same cycle.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete import olid_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   olid_req_if.sink   req_bus,
   olid_rsp_if.source rsp_bus,
   olid_csr_if.sink   csr_bus
);

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
   localparam logic [CMPW-1:0] DEPTH_EXT = CMPW'(DEPTH);

   logic [LEN_W-1:0]    cap_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  read_value_ff;
   logic [VALUE_W-1:0]  read_value_in;
   logic [STATUS_W-1:0] status_ff;
   status_type          status_in;
   logic [LEN_W-1:0]    length_ff;

   logic                accept;
   cmd_type             cmd;
   logic [CMPW-1:0]     count_ext;
   logic [CMPW-1:0]     pos_ext;
   logic [CMPW-1:0]     cap_ext;
   logic [CMPW-1:0]     ins_pos;
   logic                full;
   logic                in_list;
   cell_op_type         op;
   logic [CMPW-1:0]     cell_pos;

   logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]         left_data [DEPTH];
   logic [DATA_WIDTH-1:0]         right_data [DEPTH];
   logic [DATA_WIDTH-1:0]         ins_value;
   logic [DATA_WIDTH-1:0]         rd_data;
   logic [DATA_WIDTH+VALUE_W-1:0] value_wide;
   logic [DATA_WIDTH+VALUE_W-1:0] read_wide;

   // handshakes
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign cmd           = cmd_type'(req_bus.command);

   // compare everything at a common width
   assign count_ext = CMPW'(count_ff);
   assign pos_ext   = CMPW'(req_bus.position);
   assign cap_ext   = CMPW'(cap_ff);
   assign full      = (count_ext >= cap_ext) || (count_ext >= DEPTH_EXT);
   assign in_list   = pos_ext < count_ext;
   assign ins_pos   = (pos_ext > count_ext) ? count_ext : pos_ext;

   // shift control broadcast to the cells
   assign op.ins   = accept && (cmd == CMD_INSERT) && !full;
   assign op.del   = accept && (cmd == CMD_DELETE) && in_list;
   assign cell_pos = op.ins ? ins_pos : pos_ext;

   // keep the low data bits of the request word
   assign value_wide = {{DATA_WIDTH{1'b0}}, req_bus.value};
   assign ins_value  = value_wide[DATA_WIDTH-1:0];

   // row of cells, each wired to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i] = '0;
      end else begin : g_left
         assign left_data[i] = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data[i] = '0;
      end else begin : g_right
         assign right_data[i] = cell_data[i+1];
      end

      olid_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .POSW       (CMPW),
         .IDX        (i)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .pos        (cell_pos),
         .ins_value  (ins_value),
         .left_data  (left_data[i]),
         .right_data (right_data[i]),
         .data       (cell_data[i])
      );
   end

   // entry at the requested position, only used when it lies inside the list
   assign rd_data   = cell_data[pos_ext[IW-1:0]];
   assign read_wide = {{VALUE_W{1'b0}}, rd_data};

   // result of the command
   always_comb begin
      count_in      = count_ff;
      status_in     = ST_OK;
      read_value_in = '0;
      unique case (cmd)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         CMD_DELETE: begin
            if (!in_list) begin
               status_in = ST_OUT_RANGE;
            end else begin
               read_value_in = read_wide[VALUE_W-1:0];
               count_in      = count_ff - CW'(1);
            end
         end
         CMD_GET: begin
            if (!in_list) begin
               status_in = ST_OUT_RANGE;
            end else begin
               read_value_in = read_wide[VALUE_W-1:0];
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // control state: capacity, length, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            cap_ff <= csr_bus.data;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
         length_ff     <= LEN_W'(count_in);
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_value  = read_value_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.list_length = length_ff;

endmodule
